/* sv/roll_to_yaw_rate_deadband_law_unit_defines.svh */
// Assertion macros for the roll to yaw rate deadband law unit.
// Included by the top level; no other dependencies.
`ifndef ROLL_TO_YAW_RATE_DEADBAND_LAW_UNIT_DEFINES_SVH
`define ROLL_TO_YAW_RATE_DEADBAND_LAW_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define RYR_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define RYR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RYR_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define RYR_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* sv/ryr_pkg.sv */
// Shared widths, constants, register codes and control types for the
// roll to yaw rate deadband law unit. No dependencies.
package ryr_pkg;

    // port field widths
    localparam int QW   = 16;
    localparam int HW   = 16;
    localparam int OW   = 16;
    localparam int MRW  = 14;
    localparam int GW   = 14;
    localparam int LW   = 15;
    localparam int IDXW = 2;
    localparam int CDW  = 15;

    // datapath widths
    localparam int PW    = 32;  // quaternion products
    localparam int NW    = 33;  // squared length
    localparam int XW    = 36;  // rotation CORDIC x/y
    localparam int AW    = 21;  // rotation angle, Q.16
    localparam int YRW   = 35;  // gain compensated y
    localparam int FRACW = 28;  // fraction bits of the ratio
    localparam int SW    = 30;  // ratio, signed, 2^28 = 1.0
    localparam int SQW   = 57;  // ratio squared
    localparam int RTW   = 29;  // square root
    localparam int REMW  = 31;  // square root remainder
    localparam int VW    = 32;  // vectoring CORDIC x/y
    localparam int ANGW  = 20;  // vectoring angle, Q.16
    localparam int STEPS = 16;

    localparam logic signed [ANGW-1:0] ATAN_TAB [STEPS] = '{
        20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
        20'sd1024, 20'sd512, 20'sd256, 20'sd128, 20'sd64, 20'sd32, 20'sd16,
        20'sd8, 20'sd4, 20'sd2
    };

    localparam logic signed [AW-1:0] PI_Q16      = 21'sd205887;
    localparam logic signed [AW-1:0] HALF_PI_Q16 = 21'sd102944;
    localparam logic [15:0]          GAIN_COMP_Q16 = 16'd39797;

    // configuration register codes
    typedef enum logic [IDXW-1:0] {
        REG_MIN_ROLL     = 2'd0,
        REG_RATE_GAIN    = 2'd1,
        REG_MAX_YAW_RATE = 2'd2
    } cfg_reg_t;

    localparam logic [MRW-1:0] MIN_ROLL_RST     = 14'd143;
    localparam logic [GW-1:0]  RATE_GAIN_RST    = 14'd4096;
    localparam logic [LW-1:0]  MAX_YAW_RATE_RST = 15'd12868;

    // control that travels with each beat
    typedef struct packed {
        logic valid;
        logic zero;
    } pipe_ctl_t;

endpackage

/* sv/ryr_if.sv */
// Handshake channel interfaces: setpoint input, yaw rate output, config write.
// Depends on ryr_pkg.
interface ryr_in_if;
    logic valid;
    logic ready;
    logic signed [ryr_pkg::QW-1:0] q_w;
    logic signed [ryr_pkg::QW-1:0] q_x;
    logic signed [ryr_pkg::QW-1:0] q_y;
    logic signed [ryr_pkg::QW-1:0] q_z;
    logic signed [ryr_pkg::HW-1:0] heading;
    modport source (output valid, q_w, q_x, q_y, q_z, heading, input ready);
    modport sink (input valid, q_w, q_x, q_y, q_z, heading, output ready);
endinterface

interface ryr_out_if;
    logic valid;
    logic ready;
    logic signed [ryr_pkg::OW-1:0] yaw_rate;
    modport source (output valid, yaw_rate, input ready);
    modport sink (input valid, yaw_rate, output ready);
endinterface

interface ryr_cfg_if;
    logic valid;
    logic ready;
    logic [ryr_pkg::IDXW-1:0] index;
    logic [ryr_pkg::CDW-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* sv/ryr_rot.sv */
// Pipelined rotation CORDIC (one step per stage) plus CORDIC gain correction.
// Depends on ryr_pkg.
module ryr_rot (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  ryr_pkg::pipe_ctl_t                ctl_in,
    input  logic signed [ryr_pkg::XW-1:0]     x_in,
    input  logic signed [ryr_pkg::XW-1:0]     y_in,
    input  logic signed [ryr_pkg::AW-1:0]     a_in,
    input  logic [ryr_pkg::NW-1:0]            n_in,
    output ryr_pkg::pipe_ctl_t                ctl_out,
    output logic signed [ryr_pkg::YRW-1:0]    yr_out,
    output logic [ryr_pkg::NW-1:0]            n_out
);
    localparam int NS   = ryr_pkg::STEPS;
    localparam int XW   = ryr_pkg::XW;
    localparam int AW   = ryr_pkg::AW;
    localparam int NW   = ryr_pkg::NW;
    localparam int LOW  = 18;
    localparam int HIW  = XW - LOW;
    localparam int PHW  = HIW + 17;
    localparam int PLW  = LOW + 16;
    localparam int PRW  = PHW + LOW;

    ryr_pkg::pipe_ctl_t       ctl_reg [NS];
    logic signed [XW-1:0]     x_reg [NS];
    logic signed [XW-1:0]     y_reg [NS];
    logic signed [AW-1:0]     a_reg [NS];
    logic [NW-1:0]            n_reg [NS];

    // one CORDIC step per stage
    for (genvar i = 0; i < NS; i++) begin : g_step
        ryr_pkg::pipe_ctl_t   c_cur;
        logic signed [XW-1:0] x_cur, y_cur, dx, dy, x_next, y_next;
        logic signed [AW-1:0] a_cur, a_next, t;
        logic [NW-1:0]        n_cur;

        if (i == 0) begin : g_first
            assign c_cur = ctl_in;
            assign x_cur = x_in;
            assign y_cur = y_in;
            assign a_cur = a_in;
            assign n_cur = n_in;
        end else begin : g_rest
            assign c_cur = ctl_reg[i-1];
            assign x_cur = x_reg[i-1];
            assign y_cur = y_reg[i-1];
            assign a_cur = a_reg[i-1];
            assign n_cur = n_reg[i-1];
        end

        assign t = AW'(ryr_pkg::ATAN_TAB[i]);

        always_comb
        begin
            dx = y_cur >>> i;
            dy = x_cur >>> i;
            if (a_cur >= 0)
            begin
                x_next = x_cur - dx;
                y_next = y_cur + dy;
                a_next = a_cur - t;
            end
            else
            begin
                x_next = x_cur + dx;
                y_next = y_cur - dy;
                a_next = a_cur + t;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ctl_reg[i] <= '0;
            else if (en)
                ctl_reg[i] <= c_cur;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i] <= x_next;
                y_reg[i] <= y_next;
                a_reg[i] <= a_next;
                n_reg[i] <= n_cur;
            end
        end
    end

    // gain correction, split multiply over two stages
    ryr_pkg::pipe_ctl_t     g1_ctl_reg, g2_ctl_reg;
    logic signed [PHW-1:0]  p_hi_reg, p_hi_next;
    logic [PLW-1:0]         p_lo_reg, p_lo_next;
    logic [NW-1:0]          g1_n_reg, g2_n_reg;
    logic signed [PRW-1:0]  prod;
    logic signed [ryr_pkg::YRW-1:0] yr_reg, yr_next;
    logic signed [HIW-1:0]  y_hi;
    logic [LOW-1:0]         y_lo;

    always_comb
    begin
        y_hi      = y_reg[NS-1][XW-1:LOW];
        y_lo      = y_reg[NS-1][LOW-1:0];
        p_hi_next = y_hi * $signed({1'b0, ryr_pkg::GAIN_COMP_Q16});
        p_lo_next = y_lo * ryr_pkg::GAIN_COMP_Q16;
        prod      = (PRW'(p_hi_reg) <<< LOW) + $signed({{(PRW-PLW){1'b0}}, p_lo_reg});
        yr_next   = prod[ryr_pkg::YRW+15:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g1_ctl_reg <= '0;
            g2_ctl_reg <= '0;
        end
        else if (en)
        begin
            g1_ctl_reg <= ctl_reg[NS-1];
            g2_ctl_reg <= g1_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_hi_reg <= p_hi_next;
            p_lo_reg <= p_lo_next;
            g1_n_reg <= n_reg[NS-1];
            yr_reg   <= yr_next;
            g2_n_reg <= g1_n_reg;
        end
    end

    assign ctl_out = g2_ctl_reg;
    assign yr_out  = yr_reg;
    assign n_out   = g2_n_reg;
endmodule

/* sv/ryr_div.sv */
// Pipelined restoring divider: ratio y'/n in Q.28, one quotient bit per
// stage, saturated to plus or minus one. Depends on ryr_pkg.
module ryr_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  ryr_pkg::pipe_ctl_t               ctl_in,
    input  logic signed [ryr_pkg::YRW-1:0]   yr_in,
    input  logic [ryr_pkg::NW-1:0]           n_in,
    output ryr_pkg::pipe_ctl_t               ctl_out,
    output logic signed [ryr_pkg::SW-1:0]    s_out
);
    localparam int NW  = ryr_pkg::NW;
    localparam int YRW = ryr_pkg::YRW;
    localparam int FW  = ryr_pkg::FRACW;
    localparam int SW  = ryr_pkg::SW;

    // integer part and saturation check
    ryr_pkg::pipe_ctl_t d0_ctl_reg;
    logic               d0_neg_reg, d0_sat_reg, d0_qi_reg;
    logic [NW-1:0]      d0_r_reg, d0_n_reg;
    logic [YRW-1:0]     mag;
    logic               sat, qi;
    logic [NW-1:0]      r0;

    always_comb
    begin
        mag = yr_in[YRW-1] ? YRW'(-yr_in) : YRW'(yr_in);
        sat = mag >= {{(YRW-NW-1){1'b0}}, n_in, 1'b0};
        qi  = mag >= {{(YRW-NW){1'b0}}, n_in};
        r0  = qi ? NW'(mag - {{(YRW-NW){1'b0}}, n_in}) : NW'(mag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d0_ctl_reg <= '0;
        else if (en)
            d0_ctl_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d0_neg_reg <= yr_in[YRW-1];
            d0_sat_reg <= sat;
            d0_qi_reg  <= qi;
            d0_r_reg   <= r0;
            d0_n_reg   <= n_in;
        end
    end

    // fraction bits, one per stage
    ryr_pkg::pipe_ctl_t ctl_reg [FW];
    logic [NW-1:0]      r_reg [FW];
    logic [NW-1:0]      n_reg [FW];
    logic [FW-1:0]      q_reg [FW];
    logic               neg_reg [FW];
    logic               sat_reg [FW];

    for (genvar i = 0; i < FW; i++) begin : g_bit
        ryr_pkg::pipe_ctl_t c_cur;
        logic [NW-1:0]      r_cur, n_cur, r_next;
        logic [FW-1:0]      q_cur;
        logic               neg_cur, sat_cur, b;
        logic [NW:0]        r2;

        if (i == 0) begin : g_first
            assign c_cur   = d0_ctl_reg;
            assign r_cur   = d0_r_reg;
            assign n_cur   = d0_n_reg;
            assign q_cur   = '0;
            assign neg_cur = d0_neg_reg;
            assign sat_cur = d0_sat_reg | d0_qi_reg;
        end else begin : g_rest
            assign c_cur   = ctl_reg[i-1];
            assign r_cur   = r_reg[i-1];
            assign n_cur   = n_reg[i-1];
            assign q_cur   = q_reg[i-1];
            assign neg_cur = neg_reg[i-1];
            assign sat_cur = sat_reg[i-1];
        end

        always_comb
        begin
            r2     = {r_cur, 1'b0};
            b      = r2 >= {1'b0, n_cur};
            r_next = b ? NW'(r2 - {1'b0, n_cur}) : NW'(r2);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ctl_reg[i] <= '0;
            else if (en)
                ctl_reg[i] <= c_cur;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[i]   <= r_next;
                n_reg[i]   <= n_cur;
                q_reg[i]   <= {q_cur[FW-2:0], b};
                neg_reg[i] <= neg_cur;
                sat_reg[i] <= sat_cur;
            end
        end
    end

    // saturate and apply sign
    ryr_pkg::pipe_ctl_t     out_ctl_reg;
    logic signed [SW-1:0]   s_reg, s_next;
    logic [SW-1:0]          s_mag;

    always_comb
    begin
        s_mag  = sat_reg[FW-1] ? (SW'(1) << FW) : {{(SW-FW){1'b0}}, q_reg[FW-1]};
        s_next = neg_reg[FW-1] ? -$signed(s_mag) : $signed(s_mag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ctl_reg <= '0;
        else if (en)
            out_ctl_reg <= ctl_reg[FW-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            s_reg <= s_next;
    end

    assign ctl_out = out_ctl_reg;
    assign s_out   = s_reg;
endmodule

/* sv/ryr_isqrt.sv */
// Cosine from the ratio: floor(sqrt(2^56 - s^2)), squared then a pipelined
// digit-by-digit root, one result bit per stage. Depends on ryr_pkg.
module ryr_isqrt (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  ryr_pkg::pipe_ctl_t               ctl_in,
    input  logic signed [ryr_pkg::SW-1:0]    s_in,
    output ryr_pkg::pipe_ctl_t               ctl_out,
    output logic [ryr_pkg::RTW-1:0]          c_out,
    output logic signed [ryr_pkg::SW-1:0]    s_out
);
    localparam int SW   = ryr_pkg::SW;
    localparam int SQW  = ryr_pkg::SQW;
    localparam int VWD  = SQW + 1;
    localparam int RTW  = ryr_pkg::RTW;
    localparam int REMW = ryr_pkg::REMW;
    localparam logic [VWD-1:0] ONE_Q56 = VWD'(1) << 56;

    // square, then complement against one
    ryr_pkg::pipe_ctl_t     q0_ctl_reg, q1_ctl_reg;
    logic [SQW-1:0]         sq_reg;
    logic [VWD-1:0]         v1_reg;
    logic signed [SW-1:0]   q0_s_reg, q1_s_reg;
    logic signed [2*SW-1:0] sq_full;

    assign sq_full = s_in * s_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q0_ctl_reg <= '0;
            q1_ctl_reg <= '0;
        end
        else if (en)
        begin
            q0_ctl_reg <= ctl_in;
            q1_ctl_reg <= q0_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg   <= SQW'(sq_full);
            q0_s_reg <= s_in;
            v1_reg   <= ONE_Q56 - {1'b0, sq_reg};
            q1_s_reg <= q0_s_reg;
        end
    end

    // root bits
    ryr_pkg::pipe_ctl_t     ctl_reg [RTW];
    logic [VWD-1:0]         v_reg [RTW];
    logic [REMW-1:0]        rem_reg [RTW];
    logic [RTW-1:0]         root_reg [RTW];
    logic signed [SW-1:0]   s_reg [RTW];

    for (genvar i = 0; i < RTW; i++) begin : g_bit
        ryr_pkg::pipe_ctl_t   c_cur;
        logic [VWD-1:0]       v_cur;
        logic [REMW-1:0]      rem_cur, rem_next;
        logic [RTW-1:0]       root_cur;
        logic signed [SW-1:0] s_cur;
        logic [REMW+1:0]      shifted, trial;
        logic                 b;

        if (i == 0) begin : g_first
            assign c_cur    = q1_ctl_reg;
            assign v_cur    = v1_reg;
            assign rem_cur  = '0;
            assign root_cur = '0;
            assign s_cur    = q1_s_reg;
        end else begin : g_rest
            assign c_cur    = ctl_reg[i-1];
            assign v_cur    = v_reg[i-1];
            assign rem_cur  = rem_reg[i-1];
            assign root_cur = root_reg[i-1];
            assign s_cur    = s_reg[i-1];
        end

        always_comb
        begin
            shifted  = {rem_cur, v_cur[VWD-1:VWD-2]};
            trial    = {{(REMW-RTW){1'b0}}, root_cur, 2'b01};
            b        = shifted >= trial;
            rem_next = b ? REMW'(shifted - trial) : REMW'(shifted);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ctl_reg[i] <= '0;
            else if (en)
                ctl_reg[i] <= c_cur;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[i]    <= {v_cur[VWD-3:0], 2'b00};
                rem_reg[i]  <= rem_next;
                root_reg[i] <= {root_cur[RTW-2:0], b};
                s_reg[i]    <= s_cur;
            end
        end
    end

    assign ctl_out = ctl_reg[RTW-1];
    assign c_out   = root_reg[RTW-1];
    assign s_out   = s_reg[RTW-1];
endmodule

/* sv/ryr_vec.sv */
// Pipelined vectoring CORDIC: angle of (c, s), one step per stage.
// Depends on ryr_pkg.
module ryr_vec (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  ryr_pkg::pipe_ctl_t                ctl_in,
    input  logic [ryr_pkg::RTW-1:0]           c_in,
    input  logic signed [ryr_pkg::SW-1:0]     s_in,
    output ryr_pkg::pipe_ctl_t                ctl_out,
    output logic signed [ryr_pkg::ANGW-1:0]   ang_out
);
    localparam int NS   = ryr_pkg::STEPS;
    localparam int VW   = ryr_pkg::VW;
    localparam int ANGW = ryr_pkg::ANGW;
    localparam int RTW  = ryr_pkg::RTW;

    ryr_pkg::pipe_ctl_t     ctl_reg [NS];
    logic signed [VW-1:0]   x_reg [NS];
    logic signed [VW-1:0]   y_reg [NS];
    logic signed [ANGW-1:0] ang_reg [NS];

    for (genvar i = 0; i < NS; i++) begin : g_step
        ryr_pkg::pipe_ctl_t     c_cur;
        logic signed [VW-1:0]   x_cur, y_cur, dx, dy, x_next, y_next;
        logic signed [ANGW-1:0] ang_cur, ang_next;

        if (i == 0) begin : g_first
            assign c_cur   = ctl_in;
            assign x_cur   = $signed({{(VW-RTW){1'b0}}, c_in});
            assign y_cur   = VW'(s_in);
            assign ang_cur = '0;
        end else begin : g_rest
            assign c_cur   = ctl_reg[i-1];
            assign x_cur   = x_reg[i-1];
            assign y_cur   = y_reg[i-1];
            assign ang_cur = ang_reg[i-1];
        end

        always_comb
        begin
            dx = y_cur >>> i;
            dy = x_cur >>> i;
            if (y_cur > 0)
            begin
                x_next   = x_cur + dx;
                y_next   = y_cur - dy;
                ang_next = ang_cur + ryr_pkg::ATAN_TAB[i];
            end
            else
            begin
                x_next   = x_cur - dx;
                y_next   = y_cur + dy;
                ang_next = ang_cur - ryr_pkg::ATAN_TAB[i];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ctl_reg[i] <= '0;
            else if (en)
                ctl_reg[i] <= c_cur;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i]   <= x_next;
                y_reg[i]   <= y_next;
                ang_reg[i] <= ang_next;
            end
        end
    end

    assign ctl_out = ctl_reg[NS-1];
    assign ang_out = ang_reg[NS-1];
endmodule

/* sv/roll_to_yaw_rate_deadband_law_unit.sv */
// Top level of the roll to yaw rate deadband law unit: front end, back end,
// config registers. Depends on ryr_pkg, ryr_if, ryr_rot, ryr_div, ryr_isqrt,
// ryr_vec and the defines header.
//
// Takes one setpoint beat (quaternion plus heading) per clock unless held and
// returns one yaw rate beat per setpoint, in order, through its stages: 2 of
// products and sums, 18 for the rotation CORDIC and gain correction, 30 for
// the bit-per-stage divider, 31 for the square and bit-per-stage root, 16 for
// the vectoring CORDIC and 3 for deadband, gain and limit. The whole pipeline
// advances together; it only holds while the output register carries a beat
// the sink has not taken, so in_ch.ready follows out_ch.ready in that case.
// Config writes are taken at any time on cfg_ch and apply to beats leaving
// the back end; write only while the unit is idle.
`include "roll_to_yaw_rate_deadband_law_unit_defines.svh"

module roll_to_yaw_rate_deadband_law_unit (
    input  logic       clk,
    input  logic       rst_n,
    ryr_in_if.sink     in_ch,
    ryr_out_if.source  out_ch,
    ryr_cfg_if.sink    cfg_ch
);
    localparam int QW   = ryr_pkg::QW;
    localparam int PW   = ryr_pkg::PW;
    localparam int NW   = ryr_pkg::NW;
    localparam int XW   = ryr_pkg::XW;
    localparam int AW   = ryr_pkg::AW;
    localparam int ANGW = ryr_pkg::ANGW;
    localparam int OW   = ryr_pkg::OW;
    localparam int EW   = ANGW - 1;
    localparam int RW   = ANGW - 2;
    localparam int MW   = EW + ryr_pkg::GW + 1;
    localparam int LIMW = ryr_pkg::LW + 2;

    logic en;
    logic out_valid_reg;
    logic signed [OW-1:0] yaw_rate_reg;

    // global advance: hold only when the output beat is not taken
    assign en          = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = en;

    // config registers
    logic [ryr_pkg::MRW-1:0] min_roll_reg;
    logic [ryr_pkg::GW-1:0]  rate_gain_reg;
    logic [ryr_pkg::LW-1:0]  max_yaw_rate_reg;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_roll_reg     <= ryr_pkg::MIN_ROLL_RST;
            rate_gain_reg    <= ryr_pkg::RATE_GAIN_RST;
            max_yaw_rate_reg <= ryr_pkg::MAX_YAW_RATE_RST;
        end
        else if (cfg_ch.valid)
        begin
            case (ryr_pkg::cfg_reg_t'(cfg_ch.index))
                ryr_pkg::REG_MIN_ROLL:     min_roll_reg     <= cfg_ch.data[ryr_pkg::MRW-1:0];
                ryr_pkg::REG_RATE_GAIN:    rate_gain_reg    <= cfg_ch.data[ryr_pkg::GW-1:0];
                ryr_pkg::REG_MAX_YAW_RATE: max_yaw_rate_reg <= cfg_ch.data[ryr_pkg::LW-1:0];
                default: ;
            endcase
        end
    end

    // F1: quaternion products
    logic                  f1_valid_reg;
    logic signed [PW-1:0]  p_xz_reg, p_wy_reg, p_yz_reg, p_wx_reg;
    logic signed [PW-1:0]  p_ww_reg, p_xx_reg, p_yy_reg, p_zz_reg;
    logic signed [QW-1:0]  hd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f1_valid_reg <= 1'b0;
        else if (en)
            f1_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_xz_reg <= in_ch.q_x * in_ch.q_z;
            p_wy_reg <= in_ch.q_w * in_ch.q_y;
            p_yz_reg <= in_ch.q_y * in_ch.q_z;
            p_wx_reg <= in_ch.q_w * in_ch.q_x;
            p_ww_reg <= in_ch.q_w * in_ch.q_w;
            p_xx_reg <= in_ch.q_x * in_ch.q_x;
            p_yy_reg <= in_ch.q_y * in_ch.q_y;
            p_zz_reg <= in_ch.q_z * in_ch.q_z;
            hd_reg   <= in_ch.heading;
        end
    end

    // F2: column, length and quadrant fold of the heading angle
    ryr_pkg::pipe_ctl_t    f2_ctl_reg, f2_ctl_next;
    logic signed [XW-1:0]  f2_x_reg, f2_y_reg, f2_x_next, f2_y_next, xs, ys;
    logic signed [AW-1:0]  f2_a_reg, f2_a_next, a_raw;
    logic [NW-1:0]         f2_n_reg, f2_n_next;

    always_comb
    begin
        xs = (XW'(p_xz_reg) + XW'(p_wy_reg)) <<< 1;
        ys = (XW'(p_yz_reg) - XW'(p_wx_reg)) <<< 1;
        f2_n_next = NW'($unsigned(p_ww_reg)) + NW'($unsigned(p_xx_reg))
                  + NW'($unsigned(p_yy_reg)) + NW'($unsigned(p_zz_reg));
        a_raw = -(AW'(hd_reg) <<< 3);
        if (a_raw > ryr_pkg::HALF_PI_Q16)
        begin
            f2_x_next = -xs;
            f2_y_next = -ys;
            f2_a_next = a_raw - ryr_pkg::PI_Q16;
        end
        else if (a_raw < -ryr_pkg::HALF_PI_Q16)
        begin
            f2_x_next = -xs;
            f2_y_next = -ys;
            f2_a_next = a_raw + ryr_pkg::PI_Q16;
        end
        else
        begin
            f2_x_next = xs;
            f2_y_next = ys;
            f2_a_next = a_raw;
        end
        f2_ctl_next.valid = f1_valid_reg;
        f2_ctl_next.zero  = (f2_n_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f2_ctl_reg <= '0;
        else if (en)
            f2_ctl_reg <= f2_ctl_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f2_x_reg <= f2_x_next;
            f2_y_reg <= f2_y_next;
            f2_a_reg <= f2_a_next;
            f2_n_reg <= f2_n_next;
        end
    end

    // datapath units
    ryr_pkg::pipe_ctl_t                rot_ctl, div_ctl, sq_ctl, vec_ctl;
    logic signed [ryr_pkg::YRW-1:0]    rot_yr;
    logic [NW-1:0]                     rot_n;
    logic signed [ryr_pkg::SW-1:0]     div_s, sq_s;
    logic [ryr_pkg::RTW-1:0]           sq_c;
    logic signed [ANGW-1:0]            vec_ang;

    ryr_rot u_rot (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (f2_ctl_reg),
        .x_in    (f2_x_reg),
        .y_in    (f2_y_reg),
        .a_in    (f2_a_reg),
        .n_in    (f2_n_reg),
        .ctl_out (rot_ctl),
        .yr_out  (rot_yr),
        .n_out   (rot_n)
    );

    ryr_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (rot_ctl),
        .yr_in   (rot_yr),
        .n_in    (rot_n),
        .ctl_out (div_ctl),
        .s_out   (div_s)
    );

    ryr_isqrt u_isqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (div_ctl),
        .s_in    (div_s),
        .ctl_out (sq_ctl),
        .c_out   (sq_c),
        .s_out   (sq_s)
    );

    ryr_vec u_vec (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (sq_ctl),
        .c_in    (sq_c),
        .s_in    (sq_s),
        .ctl_out (vec_ctl),
        .ang_out (vec_ang)
    );

    // B1: roll and deadband
    ryr_pkg::pipe_ctl_t     b1_ctl_reg, b2_ctl_reg;
    logic signed [ANGW:0]   rsum;
    logic signed [RW-1:0]   roll;
    logic signed [EW-1:0]   mr, e_next, b1_e_reg;

    always_comb
    begin
        rsum = (ANGW+1)'(21'sd4) - (ANGW+1)'(vec_ang);
        roll = RW'(rsum >>> 3);
        mr   = $signed({{(EW-ryr_pkg::MRW){1'b0}}, min_roll_reg});
        if (EW'(roll) > mr)
            e_next = EW'(roll) - mr;
        else if (EW'(roll) < -mr)
            e_next = EW'(roll) + mr;
        else
            e_next = '0;
    end

    // B2: gain
    logic signed [MW-1:0] b2_prod_reg;

    // B3: round, limit, output register
    logic signed [MW-1:0]   rnd;
    logic signed [LIMW-1:0] lim, rate_c;
    logic signed [OW-1:0]   yaw_next;

    always_comb
    begin
        rnd = (b2_prod_reg + MW'(2048)) >>> 12;
        lim = $signed({2'b00, max_yaw_rate_reg});
        if (rnd > MW'(lim))
            rate_c = lim;
        else if (rnd < -MW'(lim))
            rate_c = -lim;
        else
            rate_c = LIMW'(rnd);
        yaw_next = b2_ctl_reg.zero ? '0 : OW'(rate_c);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_ctl_reg    <= '0;
            b2_ctl_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b1_ctl_reg    <= vec_ctl;
            b2_ctl_reg    <= b1_ctl_reg;
            out_valid_reg <= b2_ctl_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_e_reg     <= e_next;
            b2_prod_reg  <= b1_e_reg * $signed({1'b0, rate_gain_reg});
            yaw_rate_reg <= yaw_next;
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.yaw_rate = yaw_rate_reg;

    // checks
    logic signed [LIMW-1:0] yaw_ext;
    assign yaw_ext = LIMW'(yaw_rate_reg);

    `RYR_ASSERT_IMPL(a_rate_limited, clk, rst_n, out_valid_reg, (yaw_ext <= lim) && (yaw_ext >= -lim))
    `RYR_ASSERT_IMPL(a_hold_blocks_input, clk, rst_n, out_valid_reg && !out_ch.ready, !in_ch.ready)
    `RYR_ASSERT_NEXT(a_gain_write, clk, rst_n, cfg_ch.valid && (cfg_ch.index == ryr_pkg::IDXW'(ryr_pkg::REG_RATE_GAIN)), rate_gain_reg == $past(cfg_ch.data[ryr_pkg::GW-1:0]))
endmodule
